@@ sv/spc_pkg.sv @@
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the shape pixel classifier.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int unsigned MAX_SIDE = 4096;
    localparam int unsigned SIDE_W   = 13;
    localparam int unsigned COORD_W  = 12;
    localparam int unsigned ORIGIN_W = 14;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;

    localparam logic [1:0] CLASS_NONE   = 2'd0;
    localparam logic [1:0] CLASS_FILL   = 2'd1;
    localparam logic [1:0] CLASS_STROKE = 2'd2;

    localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

    localparam int unsigned MODE_FILL    = 0;
    localparam int unsigned MODE_OUTLINE = 1;
    localparam int unsigned MODE_ELLIPSE = 2;

    typedef enum logic [2:0] {
        REG_SHAPE_MODE  = 3'd0,
        REG_BOX_WIDTH   = 3'd1,
        REG_BOX_HEIGHT  = 3'd2,
        REG_STROKE_SIZE = 3'd3,
        REG_ORIGIN_LEFT = 3'd4,
        REG_ORIGIN_TOP  = 3'd5,
        REG_RASTER_COLS = 3'd6,
        REG_RASTER_ROWS = 3'd7
    } t_reg_idx;

    function automatic logic [SIDE_W-1:0] sat_side(input logic [SIDE_W-1:0] v);
        sat_side = (v > SIDE_MAX) ? SIDE_MAX : v;
    endfunction

endpackage

@@ sv/shape_pixel_classifier.sv @@
// ----------------------------------------------------------------------------
// shape_pixel_classifier
// Classifies raster pixels against a configured rectangle or ellipse as
// none, fill or stroke, in a five-stage pipeline.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                          Word
//  input     start high, busy low               i_pixel_col, i_pixel_row
//  result    o_valid strobe, one cycle          o_out_col, o_out_row, o_pixel_class
//  config    psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// One pixel is accepted every cycle; busy never rises.
// Each accepted pixel passes through five register stages to its result:
// capture, box tests, squares, cross products and class.
// Shape constants derived from the registers settle after a write via registered squares, then products.
// Reset is synchronous; it empties the pipeline and restores the registers.
// The receiver cannot stall, so every result is shown once for one cycle.
module shape_pixel_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spc_pkg::COORD_W-1:0]   i_pixel_col,
    input  logic [spc_pkg::COORD_W-1:0]   i_pixel_row,
    output logic                          o_valid,
    output logic [spc_pkg::COORD_W-1:0]   o_out_col,
    output logic [spc_pkg::COORD_W-1:0]   o_out_row,
    output logic [1:0]                    o_pixel_class,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spc_pkg::ADDR_W-1:0]    paddr,
    input  logic [spc_pkg::DATA_W-1:0]    pwdata,
    output logic [spc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // Configuration registers.
    logic [spc_pkg::MODE_W-1:0]          r_shape_mode;
    logic [spc_pkg::SIDE_W-1:0]          r_box_width;
    logic [spc_pkg::SIDE_W-1:0]          r_box_height;
    logic [spc_pkg::SIDE_W-1:0]          r_stroke_size;
    logic signed [spc_pkg::ORIGIN_W-1:0] r_origin_left;
    logic signed [spc_pkg::ORIGIN_W-1:0] r_origin_top;
    logic [spc_pkg::SIDE_W-1:0]          r_raster_cols;
    logic [spc_pkg::SIDE_W-1:0]          r_raster_rows;

    logic                cfg_wr;
    spc_pkg::t_reg_idx   cfg_idx;

    // Derived shape constants.
    logic [12:0]        w_sat;
    logic [12:0]        h_sat;
    logic [12:0]        s_sat;
    logic [12:0]        s_eff;
    logic signed [13:0] wi_raw;
    logic signed [13:0] hi_raw;
    logic [12:0]        wi;
    logic [12:0]        hi;
    logic [25:0]        n_w2_full;
    logic [25:0]        n_h2_full;
    logic [25:0]        n_wi2_full;
    logic [25:0]        n_hi2_full;
    logic [24:0]        r_w2;
    logic [24:0]        r_h2;
    logic [24:0]        r_wi2;
    logic [24:0]        r_hi2;
    logic               r_inner_ok;
    logic [49:0]        n_w2h2_full;
    logic [49:0]        n_wi2hi2_full;
    logic [48:0]        r_w2h2;
    logic [48:0]        r_wi2hi2;

    // Stage 1: captured pixel.
    logic        r_s1_valid;
    logic [11:0] r_s1_col;
    logic [11:0] r_s1_row;

    // Stage 1 logic: box, clip and rectangle edge tests, and centre offsets.
    logic signed [14:0] x;
    logic signed [14:0] y;
    logic signed [14:0] w_s;
    logic signed [14:0] h_s;
    logic signed [14:0] s_s;
    logic               n_s2_hit;
    logic               n_s2_edge;
    logic signed [13:0] n_s2_dx;
    logic signed [13:0] n_s2_dy;

    logic               r_s2_valid;
    logic [11:0]        r_s2_col;
    logic [11:0]        r_s2_row;
    logic               r_s2_hit;
    logic               r_s2_edge;
    logic signed [13:0] r_s2_dx;
    logic signed [13:0] r_s2_dy;

    // Stage 2 logic: squares.
    logic [27:0] n_dx_sq;
    logic [27:0] n_dy_sq;

    logic        r_s3_valid;
    logic [11:0] r_s3_col;
    logic [11:0] r_s3_row;
    logic        r_s3_hit;
    logic        r_s3_edge;
    logic [23:0] r_s3_dx2;
    logic [23:0] r_s3_dy2;

    // Stage 3 logic: cross products.
    logic [48:0] n_s4_dxh;
    logic [48:0] n_s4_dyw;
    logic [48:0] n_s4_dxhi;
    logic [48:0] n_s4_dywi;

    logic        r_s4_valid;
    logic [11:0] r_s4_col;
    logic [11:0] r_s4_row;
    logic        r_s4_hit;
    logic        r_s4_edge;
    logic [48:0] r_s4_dxh;
    logic [48:0] r_s4_dyw;
    logic [48:0] r_s4_dxhi;
    logic [48:0] r_s4_dywi;

    // Stage 4 logic: sums, compares and class.
    logic [49:0] outer_sum;
    logic [49:0] inner_sum;
    logic        in_outer;
    logic        in_inner;
    logic        fill_on;
    logic        outline_on;
    logic [1:0]  n_class;

    logic        r_o_valid;
    logic [11:0] r_o_col;
    logic [11:0] r_o_row;
    logic [1:0]  r_o_class;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = spc_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_mode  <= '0;
            r_box_width   <= '0;
            r_box_height  <= '0;
            r_stroke_size <= 13'd1;
            r_origin_left <= '0;
            r_origin_top  <= '0;
            r_raster_cols <= spc_pkg::SIDE_MAX;
            r_raster_rows <= spc_pkg::SIDE_MAX;
        end else if (cfg_wr) begin
            case (cfg_idx)
                spc_pkg::REG_SHAPE_MODE:  r_shape_mode  <= pwdata[2:0];
                spc_pkg::REG_BOX_WIDTH:   r_box_width   <= pwdata[12:0];
                spc_pkg::REG_BOX_HEIGHT:  r_box_height  <= pwdata[12:0];
                spc_pkg::REG_STROKE_SIZE: r_stroke_size <= pwdata[12:0];
                spc_pkg::REG_ORIGIN_LEFT: r_origin_left <= pwdata[13:0];
                spc_pkg::REG_ORIGIN_TOP:  r_origin_top  <= pwdata[13:0];
                spc_pkg::REG_RASTER_COLS: r_raster_cols <= pwdata[12:0];
                spc_pkg::REG_RASTER_ROWS: r_raster_rows <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            spc_pkg::REG_SHAPE_MODE:  prdata = {29'd0, r_shape_mode};
            spc_pkg::REG_BOX_WIDTH:   prdata = {19'd0, r_box_width};
            spc_pkg::REG_BOX_HEIGHT:  prdata = {19'd0, r_box_height};
            spc_pkg::REG_STROKE_SIZE: prdata = {19'd0, r_stroke_size};
            spc_pkg::REG_ORIGIN_LEFT: prdata = {18'd0, r_origin_left};
            spc_pkg::REG_ORIGIN_TOP:  prdata = {18'd0, r_origin_top};
            spc_pkg::REG_RASTER_COLS: prdata = {19'd0, r_raster_cols};
            spc_pkg::REG_RASTER_ROWS: prdata = {19'd0, r_raster_rows};
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shape constants
    // ------------------------------------------------------------------
    assign w_sat  = spc_pkg::sat_side(r_box_width);
    assign h_sat  = spc_pkg::sat_side(r_box_height);
    assign s_sat  = spc_pkg::sat_side(r_stroke_size);
    assign s_eff  = (s_sat == '0) ? 13'd1 : s_sat;
    assign wi_raw = $signed({1'b0, w_sat}) - $signed({s_eff, 1'b0});
    assign hi_raw = $signed({1'b0, h_sat}) - $signed({s_eff, 1'b0});
    assign wi     = wi_raw[13] ? 13'd0 : wi_raw[12:0];
    assign hi     = hi_raw[13] ? 13'd0 : hi_raw[12:0];

    assign n_w2_full     = w_sat * w_sat;
    assign n_h2_full     = h_sat * h_sat;
    assign n_wi2_full    = wi * wi;
    assign n_hi2_full    = hi * hi;
    assign n_w2h2_full   = r_w2 * r_h2;
    assign n_wi2hi2_full = r_wi2 * r_hi2;

    always_ff @(posedge i_clk) begin
        r_w2       <= n_w2_full[24:0];
        r_h2       <= n_h2_full[24:0];
        r_wi2      <= n_wi2_full[24:0];
        r_hi2      <= n_hi2_full[24:0];
        r_inner_ok <= r_shape_mode[spc_pkg::MODE_OUTLINE] && (wi != '0) && (hi != '0);
        r_w2h2     <= n_w2h2_full[48:0];
        r_wi2hi2   <= n_wi2hi2_full[48:0];
    end

    // ------------------------------------------------------------------
    // Stage 1
    // ------------------------------------------------------------------
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
        r_s1_col <= i_pixel_col;
        r_s1_row <= i_pixel_row;
    end

    assign x   = $signed({3'd0, r_s1_col}) - $signed({r_origin_left[13], r_origin_left});
    assign y   = $signed({3'd0, r_s1_row}) - $signed({r_origin_top[13], r_origin_top});
    assign w_s = $signed({2'd0, w_sat});
    assign h_s = $signed({2'd0, h_sat});
    assign s_s = $signed({2'd0, s_eff});

    always_comb begin
        n_s2_hit  = (w_sat != '0) && (h_sat != '0)
                 && ({1'b0, r_s1_col} < r_raster_cols)
                 && ({1'b0, r_s1_row} < r_raster_rows)
                 && !x[14] && !y[14] && (x < w_s) && (y < h_s);
        n_s2_edge = (x < s_s) || (y < s_s) || (x >= w_s - s_s) || (y >= h_s - s_s);
        n_s2_dx   = $signed({1'b0, x[11:0], 1'b1}) - $signed({1'b0, w_sat});
        n_s2_dy   = $signed({1'b0, y[11:0], 1'b1}) - $signed({1'b0, h_sat});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_col  <= r_s1_col;
        r_s2_row  <= r_s1_row;
        r_s2_hit  <= n_s2_hit;
        r_s2_edge <= n_s2_edge;
        r_s2_dx   <= n_s2_dx;
        r_s2_dy   <= n_s2_dy;
    end

    // ------------------------------------------------------------------
    // Stage 2
    // ------------------------------------------------------------------
    assign n_dx_sq = r_s2_dx * r_s2_dx;
    assign n_dy_sq = r_s2_dy * r_s2_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_col  <= r_s2_col;
        r_s3_row  <= r_s2_row;
        r_s3_hit  <= r_s2_hit;
        r_s3_edge <= r_s2_edge;
        r_s3_dx2  <= n_dx_sq[23:0];
        r_s3_dy2  <= n_dy_sq[23:0];
    end

    // ------------------------------------------------------------------
    // Stage 3
    // ------------------------------------------------------------------
    assign n_s4_dxh  = r_s3_dx2 * r_h2;
    assign n_s4_dyw  = r_s3_dy2 * r_w2;
    assign n_s4_dxhi = r_s3_dx2 * r_hi2;
    assign n_s4_dywi = r_s3_dy2 * r_wi2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
        r_s4_col  <= r_s3_col;
        r_s4_row  <= r_s3_row;
        r_s4_hit  <= r_s3_hit;
        r_s4_edge <= r_s3_edge;
        r_s4_dxh  <= n_s4_dxh;
        r_s4_dyw  <= n_s4_dyw;
        r_s4_dxhi <= n_s4_dxhi;
        r_s4_dywi <= n_s4_dywi;
    end

    // ------------------------------------------------------------------
    // Stage 4
    // ------------------------------------------------------------------
    assign outer_sum  = {1'b0, r_s4_dxh} + {1'b0, r_s4_dyw};
    assign inner_sum  = {1'b0, r_s4_dxhi} + {1'b0, r_s4_dywi};
    assign in_outer   = outer_sum <= {1'b0, r_w2h2};
    assign in_inner   = r_inner_ok && (inner_sum <= {1'b0, r_wi2hi2});
    assign fill_on    = r_shape_mode[spc_pkg::MODE_FILL];
    assign outline_on = r_shape_mode[spc_pkg::MODE_OUTLINE];

    always_comb begin
        n_class = fill_on ? spc_pkg::CLASS_FILL : spc_pkg::CLASS_NONE;
        if (!r_s4_hit) begin
            n_class = spc_pkg::CLASS_NONE;
        end else if (!r_shape_mode[spc_pkg::MODE_ELLIPSE]) begin
            if (outline_on && r_s4_edge) begin
                n_class = spc_pkg::CLASS_STROKE;
            end
        end else if (!in_outer) begin
            n_class = spc_pkg::CLASS_NONE;
        end else if (outline_on && !in_inner) begin
            n_class = spc_pkg::CLASS_STROKE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_s4_valid;
        end
        r_o_col   <= r_s4_col;
        r_o_row   <= r_s4_row;
        r_o_class <= n_class;
    end

    assign o_valid       = r_o_valid;
    assign o_out_col     = r_o_col;
    assign o_out_row     = r_o_row;
    assign o_pixel_class = r_o_class;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("Accepted pixel did not produce a result five cycles later.");

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_class == spc_pkg::CLASS_NONE
                  || o_pixel_class == spc_pkg::CLASS_FILL
                  || o_pixel_class == spc_pkg::CLASS_STROKE))
        else $error("Result carries an unused class code.");

    a_stroke_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel_class == spc_pkg::CLASS_STROKE)
            |-> $past(r_shape_mode[spc_pkg::MODE_OUTLINE]))
        else $error("Stroke class given with outline disabled.");

    a_fill_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pixel_class == spc_pkg::CLASS_FILL)
            |-> $past(r_shape_mode[spc_pkg::MODE_FILL]))
        else $error("Fill class given with fill disabled.");
`endif

endmodule
